/* src/opf_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the one-pole filter unit.
// No dependencies; the controller, datapath, filter unit, checker and testbench import this package.
package opf_pkg;

  // Default channel count and reset value of the inverse sample rate
  localparam int          OPF_CHANNELS = 8;
  localparam logic [31:0] ISR_RESET    = 32'd89478;

  // pi in Q2.22 and one in Q1.30
  localparam logic [23:0] PI_Q22  = 24'd13176795;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Reciprocals ceil(2^37 / k) for exact floor division of values below 2^30
  localparam int          RECIP_SHIFT = 37;
  localparam logic [36:0] RECIP_72 = 37'(((64'd1 << RECIP_SHIFT) + 64'd71) / 64'd72);
  localparam logic [36:0] RECIP_42 = 37'(((64'd1 << RECIP_SHIFT) + 64'd41) / 64'd42);
  localparam logic [36:0] RECIP_20 = 37'(((64'd1 << RECIP_SHIFT) + 64'd19) / 64'd20);
  localparam logic [36:0] RECIP_6  = 37'(((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6);
  localparam logic [36:0] RECIP_90 = 37'(((64'd1 << RECIP_SHIFT) + 64'd89) / 64'd90);
  localparam logic [36:0] RECIP_56 = 37'(((64'd1 << RECIP_SHIFT) + 64'd55) / 64'd56);
  localparam logic [36:0] RECIP_30 = 37'(((64'd1 << RECIP_SHIFT) + 64'd29) / 64'd30);
  localparam logic [36:0] RECIP_12 = 37'(((64'd1 << RECIP_SHIFT) + 64'd11) / 64'd12);
  localparam logic [36:0] RECIP_2  = 37'(((64'd1 << RECIP_SHIFT) + 64'd1) / 64'd2);

  // Series step indexes: sine uses 0..3, cosine 4..8
  localparam logic [3:0] TAY_FIRST    = 4'd0;
  localparam logic [3:0] TAY_SIN_LAST = 4'd3;
  localparam logic [3:0] TAY_COS_LAST = 4'd8;
  localparam logic [3:0] DIV_LAST     = 4'd15;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_W,
    ST_DIVU_LOAD,
    ST_DIVU,
    ST_U2,
    ST_TAY_INIT,
    ST_TAY_DIVC,
    ST_TAY_MUL,
    ST_SIN_OUT,
    ST_DIVG_LOAD,
    ST_DIVG,
    ST_FLT_MUL,
    ST_FLT_UPD
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_P,
    OP_MUL_W,
    OP_DIVU_LOAD,
    OP_DIV_STEP,
    OP_U2,
    OP_TAY_INIT,
    OP_TAY_DIVC,
    OP_TAY_MUL,
    OP_SIN_OUT,
    OP_DIVG_LOAD,
    OP_FLT_MUL,
    OP_FLT_UPD
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] idx;
  } dp_cmd_t;

  // Reciprocal of the series divisor for one step
  function automatic logic [36:0] div_recip(input logic [3:0] idx);
    logic [36:0] r;
    unique case (idx)
      4'd0:    r = RECIP_72;
      4'd1:    r = RECIP_42;
      4'd2:    r = RECIP_20;
      4'd3:    r = RECIP_6;
      4'd4:    r = RECIP_90;
      4'd5:    r = RECIP_56;
      4'd6:    r = RECIP_30;
      4'd7:    r = RECIP_12;
      4'd8:    r = RECIP_2;
      default: r = RECIP_2;
    endcase
    return r;
  endfunction

  // Clamp to 24-bit signed
  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    logic signed [23:0] r;
    if (v > 28'sd8388607) r = 24'sh7fffff;
    else if (v < -28'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  // Clamp to 16-bit signed
  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    logic signed [15:0] r;
    if (v > 22'sd32767) r = 16'sh7fff;
    else if (v < -22'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

/* src/opf_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input samples, filtered results, config writes.
// No dependencies.
interface opf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  channel_index;
  logic signed [15:0] sample_in;
  logic [15:0] cutoff_hz;
  logic [1:0]  filter_mode;
  logic        clear_state;

  modport source (output valid, channel_index, sample_in, cutoff_hz, filter_mode,
                  clear_state, input ready);
  modport sink (input valid, channel_index, sample_in, cutoff_hz, filter_mode,
                clear_state, output ready);
endinterface

interface opf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  channel_out;
  logic signed [15:0] sample_out;

  modport source (output valid, channel_out, sample_out, input ready);
  modport sink (input valid, channel_out, sample_out, output ready);
endinterface

interface opf_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] inverse_sample_rate;

  modport source (output valid, inverse_sample_rate, input ready);
  modport sink (input valid, inverse_sample_rate, output ready);
endinterface

/* src/opf_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module opf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/opf_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the filter unit: steps the datapath through gain, divide and update.
// Depends on opf_pkg.
module opf_ctrl import opf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        commit;

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    cmd.op    = OP_NONE;
    cmd.idx   = idx_r;
    in_ready  = 1'b0;
    commit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        cmd.op    = OP_MUL_P;
        state_nxt = ST_MUL_W;
      end
      ST_MUL_W: begin
        cmd.op    = OP_MUL_W;
        state_nxt = ST_DIVU_LOAD;
      end
      ST_DIVU_LOAD: begin
        cmd.op    = OP_DIVU_LOAD;
        cnt_nxt   = '0;
        state_nxt = ST_DIVU;
      end
      ST_DIVU: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_U2;
        end
      end
      ST_U2: begin
        cmd.op    = OP_U2;
        idx_nxt   = TAY_FIRST;
        state_nxt = ST_TAY_INIT;
      end
      ST_TAY_INIT: begin
        cmd.op    = OP_TAY_INIT;
        state_nxt = ST_TAY_DIVC;
      end
      ST_TAY_DIVC: begin
        cmd.op  = OP_TAY_DIVC;
        idx_nxt = idx_r + 4'd1;
        if (idx_r == TAY_SIN_LAST) state_nxt = ST_SIN_OUT;
        else if (idx_r == TAY_COS_LAST) state_nxt = ST_DIVG_LOAD;
        else state_nxt = ST_TAY_MUL;
      end
      ST_TAY_MUL: begin
        cmd.op    = OP_TAY_MUL;
        state_nxt = ST_TAY_DIVC;
      end
      ST_SIN_OUT: begin
        cmd.op    = OP_SIN_OUT;
        state_nxt = ST_TAY_INIT;
      end
      ST_DIVG_LOAD: begin
        cmd.op    = OP_DIVG_LOAD;
        cnt_nxt   = '0;
        state_nxt = ST_DIVG;
      end
      ST_DIVG: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_FLT_MUL;
        end
      end
      ST_FLT_MUL: begin
        cmd.op    = OP_FLT_MUL;
        state_nxt = ST_FLT_UPD;
      end
      ST_FLT_UPD: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.op    = OP_FLT_UPD;
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result beat held until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_MUL_P))
    else $error("accepted beat did not start the sequence");

  a_cnt_only_div: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 4'd0) |-> (state_r == ST_DIVU || state_r == ST_DIVG))
    else $error("divide counter live outside a divide");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TAY_DIVC) |-> (idx_r <= TAY_COS_LAST))
    else $error("series step index out of range");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed result not presented");

endmodule

/* src/opf_datapath.sv */
`timescale 1ns / 1ps
// Datapath: gain from cutoff (multiplies, shared restoring divider, sine/cosine
// series), one-pole update and state RAM. Depends on opf_pkg and opf_ram.
module opf_datapath import opf_pkg::*; #(
  parameter int CHANNELS = OPF_CHANNELS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  input  logic [2:0]         in_channel_index,
  input  logic signed [15:0] in_sample_in,
  input  logic [15:0]        in_cutoff_hz,
  input  logic [1:0]         in_filter_mode,
  input  logic               in_clear_state,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data,
  output logic [2:0]         out_channel_out,
  output logic signed [15:0] out_sample_out
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [31:0]        isr_r;
  logic [CHANNELS-1:0] vld_r;

  logic [2:0]         ch_r;
  logic [AW-1:0]      addr_r;
  logic               ok_r;
  logic signed [15:0] x_r;
  logic [15:0]        hz_r;
  logic               high_r;
  logic               clr_r;
  logic signed [23:0] s_r;
  logic [47:0]        p_r;
  logic [41:0]        w_r;
  logic [42:0]        rem_r;
  logic [42:0]        d_r;
  logic [15:0]        low_r;
  logic [15:0]        quo_r;
  logic [29:0]        u2_r;
  logic [29:0]        m_r;
  logic [30:0]        t_r;
  logic [29:0]        sn_r;
  logic signed [40:0] prod_r;
  logic [2:0]         och_r;
  logic signed [15:0] osmp_r;

  logic [23:0]        ram_rdata;
  logic               ram_we;
  logic [AW-1:0]      in_addr;
  logic               in_ok;

  logic [63:0]        wprod;
  logic [43:0]        rem2;
  logic               ge;
  logic [43:0]        rem_sub;
  logic [29:0]        u;
  logic [59:0]        uu;
  logic [66:0]        qp;
  logic [60:0]        mp;
  logic [60:0]        sp;
  logic [14:0]        g;
  logic signed [19:0] x19;
  logic signed [24:0] diff;
  logic signed [26:0] delta;
  logic signed [23:0] s1;
  logic signed [23:0] s2;
  logic signed [24:0] v;
  logic signed [25:0] vr;
  logic signed [15:0] o;

  assign in_addr = AW'(in_channel_index);
  assign in_ok   = (32'(in_channel_index) < 32'(CHANNELS));

  // Gain path arithmetic
  assign wprod   = 64'(p_r[47:8]) * 64'(PI_Q22);
  assign rem2    = {rem_r, low_r[15]};
  assign ge      = (rem2 >= {1'b0, d_r});
  assign rem_sub = rem2 - {1'b0, d_r};
  assign u       = {quo_r, 14'b0};
  assign uu      = 60'(u) * 60'(u);
  assign qp      = 67'(m_r) * 67'(div_recip(cmd.idx));
  assign mp      = 61'(u2_r) * 61'(t_r);
  assign sp      = 61'(u) * 61'(t_r);
  assign g       = quo_r[15] ? 15'h7fff : quo_r[14:0];

  // Filter update arithmetic
  assign x19   = 20'(x_r) <<< 4;
  assign diff  = 25'(x19) - 25'(s_r);
  assign delta = 27'(prod_r >>> 14);
  assign s1    = sat24(28'(s_r) + 28'(delta));
  assign s2    = sat24(28'(s1) + 28'(delta));
  assign v     = high_r ? (25'(x19) - 25'(s1)) : 25'(s1);
  assign vr    = (26'(v) + 26'sd8) >>> 4;
  assign o     = sat16(22'(vr));

  assign ram_we = (cmd.op == OP_FLT_UPD) && ok_r;

  // Config register and per-channel valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      isr_r <= ISR_RESET;
      vld_r <= '0;
    end else begin
      if (cfg_we) isr_r <= cfg_data;
      if (ram_we) vld_r[addr_r] <= 1'b1;
    end
  end

  // Datapath registers, advanced by the command
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        ch_r   <= in_channel_index;
        addr_r <= in_addr;
        ok_r   <= in_ok;
        x_r    <= in_sample_in;
        hz_r   <= in_cutoff_hz;
        high_r <= (in_filter_mode != 2'd0);
        clr_r  <= in_clear_state;
      end
      OP_MUL_P: begin
        p_r <= 48'(hz_r) * 48'(isr_r);
        s_r <= (ok_r && !clr_r && vld_r[addr_r]) ? $signed(ram_rdata) : 24'sd0;
      end
      OP_MUL_W: w_r <= wprod[63:22];
      OP_DIVU_LOAD: begin
        rem_r <= {1'b0, w_r};
        d_r   <= {1'b0, w_r} + 43'(25'd1 << 24);
        low_r <= '0;
        quo_r <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= ge ? rem_sub[42:0] : rem2[42:0];
        quo_r <= {quo_r[14:0], ge};
        low_r <= {low_r[14:0], 1'b0};
      end
      OP_U2:       u2_r <= uu[59:30];
      OP_TAY_INIT: m_r <= u2_r;
      OP_TAY_DIVC: t_r <= ONE_Q30 - {1'b0, qp[66:37]};
      OP_TAY_MUL:  m_r <= mp[59:30];
      OP_SIN_OUT:  sn_r <= sp[59:30];
      OP_DIVG_LOAD: begin
        rem_r <= 43'(sn_r[29:2]);
        low_r <= {sn_r[1:0], 14'b0};
        d_r   <= 43'(t_r);
        quo_r <= '0;
      end
      OP_FLT_MUL: prod_r <= 41'(diff) * 41'($signed({1'b0, g}));
      OP_FLT_UPD: begin
        och_r  <= ch_r;
        osmp_r <= o;
      end
      default: ;
    endcase
  end

  // Integrator store
  opf_ram #(
    .WIDTH (24),
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (s2),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  assign out_channel_out = och_r;
  assign out_sample_out  = osmp_r;

endmodule

/* src/one_pole_lp_hp_filter_unit.sv */
`timescale 1ns / 1ps
// Multichannel one-pole low-pass / high-pass filter unit.
// One item at a time: two 16-step restoring divides and a sine/cosine series
// compute the gain of each item before its one-pole update.
// The next item is taken while a finished result still waits in the output register.
// Synchronous active-low reset clears all channel integrators and loads the
// default inverse sample rate; no clearing pass is needed.
module one_pole_lp_hp_filter_unit import opf_pkg::*; #(
  parameter int CHANNELS = OPF_CHANNELS
) (
  input logic       clk,
  input logic       rst_n,
  opf_in_if.sink    in_ch,
  opf_out_if.source out_ch,
  opf_cfg_if.sink   cfg_ch
);

  dp_cmd_t cmd;
  logic    in_ready;
  logic    out_valid;

  // Config writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  opf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  opf_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_channel_index (in_ch.channel_index),
    .in_sample_in     (in_ch.sample_in),
    .in_cutoff_hz     (in_ch.cutoff_hz),
    .in_filter_mode   (in_ch.filter_mode),
    .in_clear_state   (in_ch.clear_state),
    .cfg_we           (cfg_ch.valid),
    .cfg_data         (cfg_ch.inverse_sample_rate),
    .out_channel_out  (out_ch.channel_out),
    .out_sample_out   (out_ch.sample_out)
  );

endmodule

/* dv/opf_filter_checker.sv */
`timescale 1ns / 1ps
// Checker of the one-pole filter unit: watches the input, result and config channels.
// It predicts each filtered sample and compares it; depends on opf_pkg and opf_if.sv.
module opf_filter_checker import opf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  opf_in_if    in_ch,
  opf_out_if   out_ch,
  opf_cfg_if   cfg_ch,
  output int   mismatch_count,
  output int   pending_results
);

  typedef struct {
    logic [2:0]         chan;
    logic signed [15:0] sample;
  } filt_result_t;

  filt_result_t       expected_q[$];
  logic [31:0]        isr_shadow;
  logic signed [23:0] integ_mem [OPF_CHANNELS];

  // Warped gain tan(w/(1+w)) in Q2.14, series terms floored at every step
  function automatic longint unsigned gain_q14(input logic [31:0] isr,
                                               input logic [15:0] hz);
    longint unsigned p, w, u16, u, u2, t, sn, cs, g, one;
    one = 64'd1 << 30;
    p   = 64'(hz) * 64'(isr);
    w   = ((p >> 8) * 64'd13176795) >> 22;
    u16 = (w << 16) / (w + (64'd1 << 24));
    u   = u16 << 14;
    u2  = (u * u) >> 30;
    t   = one - u2 / 72;
    t   = one - ((u2 * t) >> 30) / 42;
    t   = one - ((u2 * t) >> 30) / 20;
    t   = one - ((u2 * t) >> 30) / 6;
    sn  = (u * t) >> 30;
    t   = one - u2 / 90;
    t   = one - ((u2 * t) >> 30) / 56;
    t   = one - ((u2 * t) >> 30) / 30;
    t   = one - ((u2 * t) >> 30) / 12;
    cs  = one - ((u2 * t) >> 30) / 2;
    g   = (sn << 14) / cs;
    if (g > 64'd32767) g = 64'd32767;
    return g;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Run one sample through the channel's integrator and queue the output
  task automatic predict_sample(input logic [2:0] chan, input logic signed [15:0] x,
                                input logic [15:0] hz, input logic [1:0] mode,
                                input logic clr);
    longint s, g, x19, delta, s1, s2, v, o;
    filt_result_t r;
    s     = clr ? 0 : longint'(integ_mem[chan]);
    g     = longint'(gain_q14(isr_shadow, hz));
    x19   = longint'(x) * 16;
    delta = ((x19 - s) * g) >>> 14;
    s1    = clamp(s + delta, -8388608, 8388607);
    v     = (mode != 2'd0) ? (x19 - s1) : s1;
    o     = clamp((v + 8) >>> 4, -32768, 32767);
    s2    = clamp(s1 + delta, -8388608, 8388607);
    integ_mem[chan] = 24'(s2);
    r.chan   = chan;
    r.sample = 16'(o);
    expected_q.insert(expected_q.size(), r);
  endtask

  assign pending_results = expected_q.size();

  always @(posedge clk) begin
    filt_result_t e;
    if (!rst_n) begin
      isr_shadow <= ISR_RESET;
      for (int i = 0; i < OPF_CHANNELS; i++) integ_mem[i] = '0;
      expected_q.delete();
      mismatch_count <= 0;
    end else begin
      // track register writes
      if (cfg_ch.valid && cfg_ch.ready) isr_shadow <= cfg_ch.inverse_sample_rate;
      // compare result beat against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("ERROR: unexpected result beat ch=%0d sample=%0d",
                     out_ch.channel_out, out_ch.sample_out);
          mismatch_count <= mismatch_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.chan !== out_ch.channel_out || e.sample !== out_ch.sample_out) begin
            if (mismatch_count < 10)
              $display("ERROR: expected ch=%0d sample=%0d, got ch=%0d sample=%0d",
                       e.chan, e.sample, out_ch.channel_out, out_ch.sample_out);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      // predict each accepted input beat
      if (in_ch.valid && in_ch.ready)
        predict_sample(in_ch.channel_index, in_ch.sample_in, in_ch.cutoff_hz,
                       in_ch.filter_mode, in_ch.clear_state);
    end
  end

endmodule

/* dv/tb_one_pole_lp_hp_filter_unit.sv */
`timescale 1ns / 1ps
// Top of the one-pole filter testbench: clock, reset, stimulus and verdict.
// Depends on opf_pkg, opf_if.sv, the filter unit and opf_filter_checker.
module tb_one_pole_lp_hp_filter_unit;
  import opf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycle_count = 0;
  int   mismatch_count, pending_results;
  int   idle_pct = 0, stall_pct = 0;
  logic hold_request = 1'b0;
  int   beats_sent = 0, cfg_writes = 0;

  opf_in_if  in_bus();
  opf_out_if out_bus();
  opf_cfg_if cfg_bus();

  one_pole_lp_hp_filter_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_bus), .out_ch(out_bus), .cfg_ch(cfg_bus)
  );

  opf_filter_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_bus), .out_ch(out_bus), .cfg_ch(cfg_bus),
    .mismatch_count(mismatch_count), .pending_results(pending_results)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int held;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_bus.ready <= 1'b0;
        for (held = 0; held < 400; held++) @(negedge clk);
        hold_request = 1'b0;
      end
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one beat; entered and left at a falling edge
  task automatic send_sample(input logic [2:0] chan, input logic [15:0] x,
                             input logic [15:0] hz, input logic [1:0] mode,
                             input logic clr);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.channel_index <= chan;
    in_bus.sample_in     <= x;
    in_bus.cutoff_hz     <= hz;
    in_bus.filter_mode   <= mode;
    in_bus.clear_state   <= clr;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
    beats_sent++;
  endtask

  // Mostly realistic audio content, some full-range noise
  task automatic send_random;
    logic [15:0] hz;
    case ($urandom_range(3))
      0: hz = 16'($urandom_range(20, 2000));
      1: hz = 16'($urandom_range(2000, 24000));
      2: hz = 16'($urandom);
      default: hz = 16'($urandom_range(0, 200));
    endcase
    send_sample(3'($urandom), 16'($urandom), hz, 2'($urandom),
                $urandom_range(99) < 5);
  endtask

  // Drain all results, let the pipeline settle, then write the register
  task automatic write_isr(input logic [31:0] value);
    in_bus.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.inverse_sample_rate <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    int ph;
    in_bus.valid = 1'b0;
    in_bus.channel_index = '0;
    in_bus.sample_in = '0;
    in_bus.cutoff_hz = '0;
    in_bus.filter_mode = '0;
    in_bus.clear_state = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.inverse_sample_rate = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: field extremes, all modes, clear, zero and top cutoff
    send_sample(3'd0, 16'h7fff, 16'd1000, 2'd0, 1'b0);
    send_sample(3'd0, 16'h8000, 16'd1000, 2'd1, 1'b0);
    send_sample(3'd7, 16'h8000, 16'd65535, 2'd2, 1'b0);
    send_sample(3'd7, 16'h7fff, 16'd65535, 2'd3, 1'b0);
    send_sample(3'd7, 16'h7fff, 16'd0, 2'd0, 1'b0);
    send_sample(3'd0, 16'h0000, 16'd0, 2'd1, 1'b1);
    send_sample(3'd3, 16'h5555, 16'hffff, 2'd0, 1'b0);
    send_sample(3'd3, 16'haaaa, 16'h5555, 2'd1, 1'b1);
    send_sample(3'd5, 16'hffff, 16'haaaa, 2'd0, 1'b0);
    send_sample(3'd5, 16'h0001, 16'd20000, 2'd2, 1'b1);
    // High gain with a full-scale square: drive the integrator into saturation
    write_isr(32'hffff_ffff);
    for (ph = 0; ph < 8; ph++)
      send_sample(3'd2, ph[0] ? 16'h8000 : 16'h7fff, 16'd65535, 2'(ph), 1'b0);
    write_isr(32'h0000_0000);
    send_sample(3'd2, 16'h7fff, 16'd65535, 2'd0, 1'b0);
    send_sample(3'd2, 16'h8000, 16'd65535, 2'd1, 1'b0);

    // Random phases: varied sample rates and idling patterns
    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      case (ph)
        0: write_isr(ISR_RESET);
        3: write_isr(32'hffff_ffff);
        5: write_isr(32'd0);
        default: write_isr($urandom_range(1, 32'h0080_0000));
      endcase
      if (ph == 4) hold_request = 1'b1;
      repeat (240) send_random();
    end

    in_bus.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d sample beats over %0d register writes", beats_sent, cfg_writes);
    $display("modes, clears, cutoff and sample extremes, stalls and a long hold-off");
    if (mismatch_count == 0 && pending_results == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
